// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file fic_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while rst is high.
`define FIC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fic assertion failed");

// Next-cycle implication, muted while rst is high.
`define FIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fic assertion failed");

`endif

// ===== rtl/core/fic_pkg.sv =====
package fic_pkg;

   localparam int unsigned HdrBytes     = 16;
   localparam int unsigned PosWidth     = 17;
   localparam int unsigned DimWidth     = 12;
   localparam int unsigned LenWidth     = 2 * DimWidth + 1;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [PosWidth-1:0] PosLimit      = '1;
   localparam logic [PosWidth-1:0] MaxFrameBytes = PosWidth'(81920);

   localparam logic [31:0]         MagicReset  = 32'h4652_414D;
   localparam logic [DimWidth-1:0] WidthReset  = DimWidth'(320);
   localparam logic [DimWidth-1:0] HeightReset = DimWidth'(240);
   localparam logic [LenWidth-1:0] FrameLenReset =
      LenWidth'(HdrBytes + 320 * 240);

   // Register indexes of the configuration port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAGIC  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // Configured values plus the frame length they imply
   typedef struct packed {
      logic [31:0]         magic;
      logic [DimWidth-1:0] width;
      logic [DimWidth-1:0] height;
      logic [LenWidth-1:0] frame_len;
   } cfg_type;

   // Everything the verdict needs once the last byte is in
   typedef struct packed {
      logic [3:0][31:0]    header;
      logic [PosWidth-1:0] length;
      logic                mismatch;
   } frame_end_type;

endpackage

// ===== rtl/core/fic_channels.sv =====
interface fic_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface fic_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_valid;
   logic [31:0] sequence_number;
   logic [31:0] gap_total;
   logic [31:0] good_frames;
   logic [31:0] bad_frames;

   modport source (output valid, frame_valid, sequence_number, gap_total,
                   good_frames, bad_frames, input ready);
   modport sink   (input valid, frame_valid, sequence_number, gap_total,
                   good_frames, bad_frames, output ready);
endinterface

// ===== rtl/core/fic_csr.sv =====
module fic_csr
   import fic_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   logic [31:0]           magic_ff, magic_in;
   logic [DimWidth-1:0]   width_ff, width_in;
   logic [DimWidth-1:0]   height_ff, height_in;
   logic [LenWidth-1:0]   frame_len_ff, frame_len_in;
   logic [2*DimWidth-1:0] pixels;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      magic_in  = magic_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAGIC:  magic_in  = csr_wdata[31:0];
            CSR_WIDTH:  width_in  = csr_wdata[DimWidth-1:0];
            CSR_HEIGHT: height_in = csr_wdata[DimWidth-1:0];
            default: ;
         endcase
      end
   end

   // Expected frame length follows the dimensions, next cycle
   assign pixels       = (2*DimWidth)'(width_ff) * (2*DimWidth)'(height_ff);
   assign frame_len_in = LenWidth'(pixels) + LenWidth'(HdrBytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= MagicReset;
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
         frame_len_ff <= FrameLenReset;
      end else begin
         magic_ff     <= magic_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         frame_len_ff <= frame_len_in;
      end
   end

   assign cfg = '{magic: magic_ff, width: width_ff, height: height_ff,
                  frame_len: frame_len_ff};

endmodule

// ===== rtl/core/fic_byte_stage.sv =====
module fic_byte_stage
   import fic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   input  logic          end_taken,
   output logic          end_valid,
   output frame_end_type end_rec
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [3:0][31:0]    hdr_ff, hdr_in;
   logic                mismatch_ff, mismatch_in;
   logic                end_valid_ff;
   frame_end_type       end_rec_ff;
   logic [7:0]          want;

   // Place header bytes, compare pixel bytes against the sequence ramp
   always_comb begin
      hdr_in      = hdr_ff;
      mismatch_in = mismatch_ff;
      want        = hdr_ff[1][7:0] + pos_ff[7:0] - 8'(HdrBytes);
      if (pos_ff < PosWidth'(HdrBytes)) begin
         hdr_in[pos_ff[3:2]][{pos_ff[1:0], 3'b000} +: 8] = data_byte;
      end else if (data_byte != want) begin
         mismatch_in = 1'b1;
      end
      pos_in = (pos_ff != PosLimit) ? pos_ff + PosWidth'(1) : PosLimit;
   end

   // Advance per transfer; hand the frame off and clear on the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_ff       <= '0;
         mismatch_ff  <= 1'b0;
         end_valid_ff <= 1'b0;
      end else begin
         if (take && last_byte) begin
            pos_ff       <= '0;
            hdr_ff       <= '0;
            mismatch_ff  <= 1'b0;
            end_valid_ff <= 1'b1;
         end else begin
            if (take) begin
               pos_ff      <= pos_in;
               hdr_ff      <= hdr_in;
               mismatch_ff <= mismatch_in;
            end
            if (end_taken) begin
               end_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Frame record carries no reset
   always_ff @(posedge clock) begin
      if (take && last_byte) begin
         end_rec_ff <= '{header: hdr_in, length: pos_in, mismatch: mismatch_in};
      end
   end

   assign end_valid = end_valid_ff;
   assign end_rec   = end_rec_ff;

endmodule

// ===== rtl/core/fic_verdict.sv =====
module fic_verdict
   import fic_pkg::*;
#(
   parameter logic [PosWidth-1:0] MaxFrameLen = MaxFrameBytes
)
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          end_valid,
   input  frame_end_type end_rec,
   output logic          end_taken,
   fic_rsp_if.source     rsp
);

   logic [31:0] good_ff, good_in;
   logic [31:0] bad_ff, bad_in;
   logic [31:0] gap_ff, gap_in;
   logic [31:0] prev_ff, prev_in;
   logic        rsp_valid_ff;
   logic        frame_valid_ff;
   logic [31:0] seq_ff;
   logic        hdr_ok;
   logic        valid;
   logic [31:0] seq;

   assign end_taken = end_valid && (!rsp_valid_ff || rsp.ready);

   // Judge the frame and work out the counters after it
   always_comb begin
      hdr_ok = end_rec.length >= PosWidth'(HdrBytes);
      seq    = hdr_ok ? end_rec.header[1] : '0;
      valid  = hdr_ok
            && end_rec.header[0] == cfg.magic
            && end_rec.header[2] == 32'(cfg.width)
            && end_rec.header[3] == 32'(cfg.height)
            && end_rec.length <= MaxFrameLen
            && LenWidth'(end_rec.length) == cfg.frame_len
            && !end_rec.mismatch;
      good_in = valid ? good_ff + 32'd1 : good_ff;
      bad_in  = valid ? bad_ff : bad_ff + 32'd1;
      prev_in = valid ? seq : prev_ff;
      gap_in  = (valid && good_ff != '0) ? gap_ff + seq - prev_ff - 32'd1 : gap_ff;
   end

   // Update counters and the output valid on each verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         good_ff      <= '0;
         bad_ff       <= '0;
         gap_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (end_taken) begin
            good_ff      <= good_in;
            bad_ff       <= bad_in;
            gap_ff       <= gap_in;
            prev_ff      <= prev_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the per-frame payload until the next verdict
   always_ff @(posedge clock) begin
      if (end_taken) begin
         frame_valid_ff <= valid;
         seq_ff         <= seq;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.frame_valid     = frame_valid_ff;
   assign rsp.sequence_number = seq_ff;
   assign rsp.gap_total       = gap_ff;
   assign rsp.good_frames     = good_ff;
   assign rsp.bad_frames      = bad_ff;

endmodule

// ===== rtl/core/frame_integrity_checker.sv =====
// Channel   Dir  Transfer carries
// req_chan  in   data_byte, last_byte: one frame byte
// rsp_chan  out  frame_valid, sequence_number, gap_total, good_frames,
//                bad_frames: one verdict per frame
// csr_*     in   write-only: magic, width, height
//
// One byte is taken per cycle unless a finished frame waits on a stalled
// verdict; a verdict leaves via the byte register, then the verdict and
// counter register. Back-to-back frames, even one byte long, sustain one
// byte per cycle while the receiver keeps up. A stalled verdict holds
// req_chan.ready low only when a further frame end is already waiting
// behind it. Synchronous reset clears position, header, counters and
// restores the register defaults; no clearing pass is needed.
module frame_integrity_checker
   import fic_pkg::*;
#(
   parameter logic [PosWidth-1:0] MaxFrameLen = MaxFrameBytes
)
(
   input  logic                    clock,
   input  logic                    reset,
   fic_req_if.sink                 req_chan,
   fic_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type       cfg;
   logic          take;
   logic          end_valid;
   logic          end_taken;
   frame_end_type end_rec;

   // Refuse a byte only while a finished frame cannot move on
   assign req_chan.ready = !end_valid || end_taken;
   assign take           = req_chan.valid && req_chan.ready;

   fic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fic_byte_stage u_byte (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .end_taken (end_taken),
      .end_valid (end_valid),
      .end_rec   (end_rec)
   );

   fic_verdict #(
      .MaxFrameLen (MaxFrameLen)
   ) u_verdict (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .end_valid (end_valid),
      .end_rec   (end_rec),
      .end_taken (end_taken),
      .rsp       (rsp_chan)
   );

endmodule

// ===== rtl/core/fic_checker.sv =====
`include "assert_macros.svh"

module fic_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        frame_valid,
   input logic [31:0] sequence_number,
   input logic [31:0] good_frames,
   input logic [31:0] bad_frames
);

   logic        xfer;
   logic [31:0] good_seen_ff;
   logic [31:0] bad_seen_ff;

   assign xfer = rsp_valid && rsp_ready;

   // Track the counters of the last verdict transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         good_seen_ff <= '0;
         bad_seen_ff  <= '0;
      end else if (xfer) begin
         good_seen_ff <= good_frames;
         bad_seen_ff  <= bad_frames;
      end
   end

   `FIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(frame_valid) && $stable(sequence_number) && $stable(good_frames) && $stable(bad_frames))
   `FIC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `FIC_ASSERT_SAME(a_good_step, clock, reset, xfer && frame_valid, good_frames == good_seen_ff + 32'd1 && bad_frames == bad_seen_ff)
   `FIC_ASSERT_SAME(a_bad_step, clock, reset, xfer && !frame_valid, bad_frames == bad_seen_ff + 32'd1 && good_frames == good_seen_ff)

endmodule

bind frame_integrity_checker fic_checker u_fic_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .frame_valid     (rsp_chan.frame_valid),
   .sequence_number (rsp_chan.sequence_number),
   .good_frames     (rsp_chan.good_frames),
   .bad_frames      (rsp_chan.bad_frames)
);

// ===== bench/frame_integrity_checker_test.sv =====
module frame_integrity_checker_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fic_pkg::*;

   // Index with no register behind it; writes to it must be ignored
   localparam logic [CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned ROUND_BYTES = 235;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct {
      logic        ok;
      logic [31:0] seq;
      logic [31:0] gaps;
      logic [31:0] good;
      logic [31:0] bad;
   } verdict_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;
   logic                    steady;
   logic                    rsp_hold;
   event                    hold_rsp;

   fic_req_if req_if();
   fic_rsp_if rsp_if();

   frame_byte_type bytes_to_send[$];
   verdict_type    verdicts_due[$];
   int unsigned queued_bytes;
   int unsigned mismatches;

   // Tracked block state and configured values
   logic [PosWidth-1:0] trk_pos;
   logic [31:0]         trk_hdr [4];
   logic                trk_mism;
   logic [31:0]         trk_good;
   logic [31:0]         trk_bad;
   logic [31:0]         trk_prev;
   logic [31:0]         trk_gaps;
   logic [31:0]         want_magic;
   logic [DimWidth-1:0] want_width;
   logic [DimWidth-1:0] want_height;

   frame_integrity_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic report_error(input string msg);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   function automatic void apply_csr(input logic [CsrIdxWidth-1:0] idx,
                                     input logic [31:0] value);
      case (idx)
         CSR_MAGIC:  want_magic = value;
         CSR_WIDTH:  want_width = value[DimWidth-1:0];
         CSR_HEIGHT: want_height = value[DimWidth-1:0];
         default: ;
      endcase
   endfunction

   // Fold one accepted byte into the tracked frame; on the last byte
   // work out the verdict and the counters after it
   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      logic [31:0] want_len;
      logic [31:0] seq;
      logic [7:0]  pix;
      logic        ok;
      verdict_type v;
      if (trk_pos < HdrBytes) begin
         trk_hdr[trk_pos[3:2]] |= 32'(b) << (8 * trk_pos[1:0]);
      end else begin
         pix = 8'(trk_hdr[1] + (32'(trk_pos) - HdrBytes));
         if (b != pix) begin
            trk_mism = 1'b1;
         end
      end
      if (trk_pos != PosLimit) begin
         trk_pos++;
      end
      if (!last) begin
         return;
      end
      seq = '0;
      ok = 1'b0;
      if (trk_pos >= HdrBytes) begin
         seq = trk_hdr[1];
         want_len = HdrBytes + 32'(want_width) * 32'(want_height);
         ok = trk_hdr[0] == want_magic && trk_hdr[2] == 32'(want_width) &&
              trk_hdr[3] == 32'(want_height) && trk_pos <= MaxFrameBytes &&
              32'(trk_pos) == want_len && !trk_mism;
      end
      // Gaps count only between good frames
      if (ok) begin
         if (trk_good != 0 && seq != trk_prev + 32'd1) begin
            trk_gaps += seq - trk_prev - 32'd1;
         end
         trk_prev = seq;
         trk_good++;
      end else begin
         trk_bad++;
      end
      v.ok = ok;
      v.seq = seq;
      v.gaps = trk_gaps;
      v.good = trk_good;
      v.bad = trk_bad;
      verdicts_due.push_back(v);
      trk_pos = '0;
      trk_hdr = '{default: '0};
      trk_mism = 1'b0;
   endfunction

   // Build a frame with the given header words; corrupt_at picks one
   // byte to damage, -1 for none
   task automatic queue_frame(input logic [31:0] magic, input logic [31:0] seq,
                              input logic [31:0] wfield, input logic [31:0] hfield,
                              input int unsigned npix, input int corrupt_at);
      logic [31:0] words [4];
      frame_byte_type fb;
      int unsigned total;
      int unsigned i;
      words = '{magic, seq, wfield, hfield};
      total = HdrBytes + npix;
      for (i = 0; i < total; i++) begin
         if (i < HdrBytes) begin
            fb.data = words[i / 4][8 * (i % 4) +: 8];
         end else begin
            fb.data = 8'(seq + (i - HdrBytes));
         end
         if (int'(i) == corrupt_at) begin
            fb.data ^= 8'($urandom_range(255, 1));
         end
         fb.last = (i == total - 1);
         bytes_to_send.push_back(fb);
      end
      queued_bytes += total;
   endtask

   task automatic queue_noise(input int unsigned n);
      frame_byte_type fb;
      int unsigned i;
      for (i = 0; i < n; i++) begin
         fb.data = 8'($urandom);
         fb.last = (i == n - 1);
         bytes_to_send.push_back(fb);
      end
      queued_bytes += n;
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_csr(idx, value);
   endtask

   task automatic program_frame_shape(input logic [31:0] magic, input logic [31:0] w,
                                      input logic [31:0] h);
      write_csr(CSR_MAGIC, magic);
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold off until every byte is sent and every verdict is back
   task automatic settle();
      while (bytes_to_send.size() != 0 || req_if.valid || verdicts_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Drive one byte per transfer, idling now and then
   always @(posedge clock) begin : drive_bytes
      frame_byte_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
            nxt = bytes_to_send.pop_front();
            req_if.valid <= 1'b1;
            req_if.data_byte <= nxt.data;
            req_if.last_byte <= nxt.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Check verdicts against the oldest expectation, then track accepted bytes
   always @(posedge clock) begin : watch_verdicts
      verdict_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdicts_due.size() == 0) begin
               report_error($sformatf("verdict with none due, seq %h",
                                      rsp_if.sequence_number));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_if.frame_valid !== want.ok) begin
                  report_error($sformatf("frame_valid got %b want %b",
                                         rsp_if.frame_valid, want.ok));
               end
               if (rsp_if.sequence_number !== want.seq) begin
                  report_error($sformatf("sequence_number got %h want %h",
                                         rsp_if.sequence_number, want.seq));
               end
               if (rsp_if.gap_total !== want.gaps) begin
                  report_error($sformatf("gap_total got %h want %h",
                                         rsp_if.gap_total, want.gaps));
               end
               if (rsp_if.good_frames !== want.good) begin
                  report_error($sformatf("good_frames got %h want %h",
                                         rsp_if.good_frames, want.good));
               end
               if (rsp_if.bad_frames !== want.bad) begin
                  report_error($sformatf("bad_frames got %h want %h",
                                         rsp_if.bad_frames, want.bad));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            absorb_byte(req_if.data_byte, req_if.last_byte);
         end
         rsp_if.ready <= !rsp_hold && (steady || $urandom_range(99) >= 9);
      end
   end

   // Long receiver stall, counted here
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(hold_rsp);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      #4_000_000;
      $display("frame_integrity_checker: mismatch");
      $finish;
   end

   initial begin
      logic [31:0] gen_seq;
      logic [31:0] seq;
      logic [31:0] magic;
      logic [31:0] w;
      logic [31:0] h;
      int unsigned npix;
      int unsigned start;
      int unsigned pick;
      int unsigned round;

      reset = 1'b1;
      steady = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      queued_bytes = 0;
      mismatches = 0;
      trk_pos = '0;
      trk_hdr = '{default: '0};
      trk_mism = 1'b0;
      trk_good = '0;
      trk_bad = '0;
      trk_prev = '0;
      trk_gaps = '0;
      want_magic = MagicReset;
      want_width = WidthReset;
      want_height = HeightReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: short frames, header only, too few pixels, bad magic
      queue_noise(1);
      queue_noise(15);
      queue_frame(MagicReset, 32'd7, 320, 240, 0, -1);
      queue_frame(MagicReset, 32'd9, 320, 240, 4, -1);
      queue_frame(MagicReset ^ 32'd1, 32'd10, 320, 240, 4, -1);
      settle();

      // Zero magic, width masked down to zero, tallest height
      program_frame_shape(32'h0, 32'hABCD_E000, 32'h0000_0FFF);
      queue_frame(32'h0, 32'd10, 0, 4095, 0, -1);
      queue_frame(32'h0, 32'd10, 0, 4095, 0, -1);
      queue_frame(32'h0, 32'd20, 0, 4095, 0, -1);
      queue_frame(32'h0, 32'd21, 32'h0000_1000, 4095, 0, -1);
      queue_frame(32'h0, 32'd21, 0, 4095, 1, -1);
      settle();

      // All-ones magic, short single row; sequence at its top
      program_frame_shape(32'hFFFF_FFFF, 32'd3, 32'd1);
      queue_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 1, 3, -1);
      queue_frame(32'hFFFF_FFFF, 32'h0, 3, 1, 3, 17);
      settle();

      // Single column; sequence wraps to zero; stray register index
      program_frame_shape(32'hFFFF_FFFF, 32'd1, 32'd2);
      write_csr(CSR_UNUSED, 32'h0000_0005);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      queue_frame(32'hFFFF_FFFF, 32'h0, 1, 2, 2, -1);
      settle();

      // Receiver stalls while short frames keep coming
      magic = $urandom;
      program_frame_shape(magic, 32'd2, 32'd1);
      -> hold_rsp;
      for (int k = 0; k < 60; k++) begin
         if ($urandom_range(3) == 0) begin
            queue_frame(magic, $urandom, 2, 1, 2, -1);
         end else begin
            queue_noise($urandom_range(3, 1));
         end
      end
      settle();

      // Random rounds: mostly well-formed frames, some broken, some noise
      gen_seq = $urandom;
      for (round = 0; round < 4; round++) begin
         case (round)
            0: magic = 32'h0;
            1: magic = 32'hFFFF_FFFF;
            default: magic = $urandom;
         endcase
         w = $urandom_range(4, 1);
         h = $urandom_range(3, 1);
         program_frame_shape(magic, w | ($urandom << DimWidth), h);
         steady <= (round == 0);
         start = queued_bytes;
         while (queued_bytes - start < ROUND_BYTES) begin
            npix = w * h;
            pick = $urandom_range(99);
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: seq = gen_seq + 32'd1;
               6: seq = gen_seq;
               7: seq = gen_seq + $urandom_range(1000, 2);
               default: seq = $urandom;
            endcase
            if (pick < 65) begin
               queue_frame(magic, seq, w, h, npix, -1);
               gen_seq = seq;
            end else if (pick < 80) begin
               case ($urandom_range(5))
                  0: queue_frame(magic ^ (32'd1 << $urandom_range(31)), seq, w, h, npix, -1);
                  1: queue_frame(magic, seq, w ^ (32'd1 << $urandom_range(31)), h, npix, -1);
                  2: queue_frame(magic, seq, w, h ^ (32'd1 << $urandom_range(31)), npix, -1);
                  3: queue_frame(magic, seq, w, h, npix + 1, -1);
                  4: queue_frame(magic, seq, w, h, npix - 1, -1);
                  default: queue_frame(magic, seq, w, h, npix,
                                       int'(HdrBytes + $urandom_range(npix - 1)));
               endcase
            end else if (pick < 90) begin
               queue_noise($urandom_range(15, 1));
            end else begin
               queue_noise($urandom_range(40, 16));
            end
            // Pause the sender mid-round until everything is back
            if (round == 2 && queued_bytes - start > ROUND_BYTES / 2 &&
                queued_bytes - start < ROUND_BYTES / 2 + 20) begin
               settle();
            end
         end
         settle();
         steady <= 1'b0;
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("frame_integrity_checker: match");
      end else begin
         $display("frame_integrity_checker: mismatch");
      end
      $finish;
   end

endmodule
